[hdl/card_number_luhn_classify_defines.svh]
// assertion macros for the card number luhn classifier
// used by card_number_luhn_classify.sv; expects clk and rst_n in scope
`ifndef CARD_NUMBER_LUHN_CLASSIFY_DEFINES_SVH
`define CARD_NUMBER_LUHN_CLASSIFY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CNL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CNL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cnl_pkg.sv]
// shared types, constants and the double-dabble adjust for the luhn classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cnl_pkg;

    localparam int MAX_DIGITS = 19;
    localparam int BIN_W      = 63;
    localparam int BCD_W      = MAX_DIGITS * 4;
    localparam int BIT_CNT_W  = $clog2(BIN_W);
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int COUNT_W    = 5;
    localparam int PAIR_W     = 7;
    localparam int KIND_W     = 2;

    typedef logic [BIN_W-1:0]     bin_t;
    typedef logic [BCD_W-1:0]     bcd_t;
    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;
    typedef logic [DIG_IDX_W-1:0] dig_idx_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [PAIR_W-1:0]    pair_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [3:0]           digit_t;

    localparam kind_t KIND_INVALID = 2'd0;
    localparam kind_t KIND_AMEX    = 2'd1;
    localparam kind_t KIND_MASTER  = 2'd2;
    localparam kind_t KIND_VISA    = 2'd3;

    localparam pair_t  PAIR_AMEX_A   = 7'd34;
    localparam pair_t  PAIR_AMEX_B   = 7'd37;
    localparam pair_t  PAIR_MASTER_LO = 7'd51;
    localparam pair_t  PAIR_MASTER_HI = 7'd55;
    localparam digit_t LEAD_VISA     = 4'd4;
    localparam count_t LEN_AMEX      = 5'd15;
    localparam count_t LEN_MASTER    = 5'd16;
    localparam count_t LEN_VISA_A    = 5'd13;
    localparam count_t LEN_VISA_B    = 5'd16;

    // add three to every bcd digit of five or more, ready for the next shift
    function automatic bcd_t dabble(bcd_t v);
        bcd_t   r;
        digit_t d;
        r = v;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            d = v[k*4 +: 4];
            if (d >= 4'd5)
            begin
                r[k*4 +: 4] = d + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/card_number_luhn_classify.sv]
// luhn check, digit count, leading pair and card class of a binary card number
// one request at a time: in_stall stays high from an accepted request until its result is loaded
// the work is a bit-serial binary-to-bcd shift followed by a one-digit-a-cycle scan
// a finished result sits in the output register while the next request is taken
// rst_n asynchronous active low clears the control state; no result pending after reset
// depends on cnl_pkg and card_number_luhn_classify_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "card_number_luhn_classify_defines.svh"

module card_number_luhn_classify
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [cnl_pkg::BIN_W-1:0]  card_number,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            luhn_valid,
    output logic [cnl_pkg::KIND_W-1:0]      card_kind,
    output logic [cnl_pkg::COUNT_W-1:0]     digit_count,
    output logic [cnl_pkg::PAIR_W-1:0]      leading_pair
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_DIGS = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        state_reg,   state_next;
    cnl_pkg::bin_t     bin_reg,     bin_next;
    cnl_pkg::bcd_t     bcd_reg,     bcd_next;
    cnl_pkg::bit_cnt_t bit_cnt_reg, bit_cnt_next;
    cnl_pkg::dig_idx_t dig_idx_reg, dig_idx_next;
    cnl_pkg::digit_t   sum_reg,     sum_next;
    cnl_pkg::count_t   count_reg,   count_next;
    cnl_pkg::digit_t   prev_reg,    prev_next;
    cnl_pkg::digit_t   hi_reg,      hi_next;
    cnl_pkg::digit_t   lo_reg,      lo_next;

    logic              out_valid_reg, out_valid_next;
    logic              luhn_reg;
    cnl_pkg::kind_t    kind_reg;
    cnl_pkg::count_t   cnt_out_reg;
    cnl_pkg::pair_t    pair_out_reg;

    logic              in_acc;
    logic              load_out;
    cnl_pkg::bcd_t     bcd_adj;
    cnl_pkg::digit_t   cur_dig;
    cnl_pkg::digit_t   add_val;
    logic [4:0]        sum_tmp;
    logic              res_valid;
    cnl_pkg::pair_t    res_pair;
    cnl_pkg::kind_t    res_kind;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);
    assign cur_dig  = bcd_reg[3:0];
    assign bcd_adj  = cnl_pkg::dabble(bcd_reg);

    // luhn contribution: odd places doubled with digits of the product summed
    always_comb
    begin
        if (dig_idx_reg[0])
        begin
            if (cur_dig < 4'd5)
                add_val = {cur_dig[2:0], 1'b0};
            else
                add_val = {cur_dig[2:0], 1'b0} + 4'd7;  // 2d - 9 kept to four bits
        end
        else
        begin
            add_val = cur_dig;
        end
        sum_tmp = {1'b0, sum_reg} + {1'b0, add_val};
    end

    // final classification from the scan registers
    always_comb
    begin
        res_valid = (sum_reg == 4'd0);
        res_pair  = ({3'b000, hi_reg} << 3) + ({3'b000, hi_reg} << 1) + {3'b000, lo_reg};
        res_kind  = cnl_pkg::KIND_INVALID;
        if (res_valid)
        begin
            if (res_pair == cnl_pkg::PAIR_AMEX_A || res_pair == cnl_pkg::PAIR_AMEX_B)
            begin
                if (count_reg == cnl_pkg::LEN_AMEX)
                    res_kind = cnl_pkg::KIND_AMEX;
            end
            else if (res_pair >= cnl_pkg::PAIR_MASTER_LO
                     && res_pair <= cnl_pkg::PAIR_MASTER_HI)
            begin
                if (count_reg == cnl_pkg::LEN_MASTER)
                    res_kind = cnl_pkg::KIND_MASTER;
            end
            else if (hi_reg == cnl_pkg::LEAD_VISA)
            begin
                if (count_reg == cnl_pkg::LEN_VISA_A || count_reg == cnl_pkg::LEN_VISA_B)
                    res_kind = cnl_pkg::KIND_VISA;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_idx_next = dig_idx_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    bin_next     = card_number;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // one binary bit in per cycle, msb first
                bcd_next     = {bcd_adj[cnl_pkg::BCD_W-2:0], bin_reg[cnl_pkg::BIN_W-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == cnl_pkg::bit_cnt_t'(cnl_pkg::BIN_W - 1))
                begin
                    dig_idx_next = '0;
                    sum_next     = '0;
                    count_next   = '0;
                    prev_next    = '0;
                    hi_next      = '0;
                    lo_next      = '0;
                    state_next   = ST_DIGS;
                end
            end
            ST_DIGS:
            begin
                // one decimal digit per cycle, least significant first
                sum_next  = (sum_tmp >= 5'd10) ? 4'(sum_tmp - 5'd10) : sum_tmp[3:0];
                prev_next = cur_dig;
                bcd_next  = bcd_reg >> 4;
                if (cur_dig != 4'd0)
                begin
                    count_next = cnl_pkg::count_t'(dig_idx_reg) + 1'b1;
                    if (dig_idx_reg == '0)
                    begin
                        hi_next = 4'd0;
                        lo_next = cur_dig;
                    end
                    else
                    begin
                        hi_next = cur_dig;
                        lo_next = prev_reg;
                    end
                end
                dig_idx_next = dig_idx_reg + 1'b1;
                if (dig_idx_reg == cnl_pkg::dig_idx_t'(cnl_pkg::MAX_DIGITS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_idx_reg   <= dig_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        prev_reg  <= prev_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        if (load_out)
        begin
            luhn_reg     <= res_valid;
            kind_reg     <= res_kind;
            cnt_out_reg  <= count_reg;
            pair_out_reg <= res_pair;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luhn_valid   = luhn_reg;
    assign card_kind    = kind_reg;
    assign digit_count  = cnt_out_reg;
    assign leading_pair = pair_out_reg;

    `CNL_ASSERT_NXT(a_req_starts_conv, in_valid && !in_stall,
        state_reg == ST_CONV && bit_cnt_reg == '0, "request did not start conversion")
    `CNL_ASSERT_IMP(a_result_from_fin, $rose(out_valid), $past(state_reg) == ST_FIN,
        "result appeared outside the finishing step")
    `CNL_ASSERT_IMP(a_count_bounded, state_reg == ST_DIGS,
        count_reg <= cnl_pkg::count_t'(dig_idx_reg), "digit count ahead of scan position")
    `CNL_ASSERT_IMP(a_fail_is_invalid, out_valid && !luhn_valid,
        card_kind == cnl_pkg::KIND_INVALID, "failed luhn check given a card class")

endmodule

`default_nettype wire
